// ===== hw/rtl/tmsb_pkg.sv =====
// Package with operation and result codes, port widths and control structs of the timer bank.
package tmsb_pkg;

  localparam int OP_W       = 2;
  localparam int KIND_W     = 3;
  localparam int SLOT_ID_W  = 3;
  localparam int TIMEOUT_W  = 32;
  localparam int S_TDATA_W  = 40;
  localparam int M_TDATA_W  = 8;
  localparam int M_TUSER_W  = 4;

  localparam logic [OP_W-1:0] OP_TICK  = 2'd0;
  localparam logic [OP_W-1:0] OP_START = 2'd1;
  localparam logic [OP_W-1:0] OP_STOP  = 2'd2;

  localparam logic [KIND_W-1:0] KIND_STARTED = 3'd0;
  localparam logic [KIND_W-1:0] KIND_FULL    = 3'd1;
  localparam logic [KIND_W-1:0] KIND_STOPPED = 3'd2;
  localparam logic [KIND_W-1:0] KIND_ALREADY = 3'd3;
  localparam logic [KIND_W-1:0] KIND_EXPIRED = 3'd4;

  typedef struct packed {
    logic accept;
    logic scan_start;
    logic scan_step;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic hit;
    logic pend_valid;
    logic can_load;
  } status_t;

endpackage

// ===== hw/rtl/tmsb_ctrl.sv =====
// Controller state machine that sequences transactions and the slot scan of a tick.
module tmsb_ctrl #(
  parameter int NUM_SLOTS = 8
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_tvalid,
  input  logic [tmsb_pkg::OP_W-1:0]   op,
  input  tmsb_pkg::status_t           status,
  output logic                        s_tready,
  output tmsb_pkg::cmd_t              cmd,
  output logic [((NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1)-1:0] scan_idx
);

  localparam int SW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam logic [SW-1:0] LAST_IDX = SW'(NUM_SLOTS - 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0]    state;
  logic [1:0]    state_next;
  logic [SW-1:0] scan_idx_next;

  always_comb begin
    s_tready       = (state == ST_IDLE) && status.can_load;
    cmd.accept     = s_tvalid && s_tready;
    cmd.scan_start = cmd.accept && (op == tmsb_pkg::OP_TICK);
    cmd.scan_step  = (state == ST_SCAN) &&
                     !(status.hit && status.pend_valid && !status.can_load);
    cmd.finish     = (state == ST_DONE) && status.can_load;
  end

  always_comb begin
    state_next    = state;
    scan_idx_next = scan_idx;
    unique case (state)
      ST_IDLE: begin
        if (cmd.scan_start) begin
          state_next    = ST_SCAN;
          scan_idx_next = '0;
        end
      end
      ST_SCAN: begin
        if (cmd.scan_step) begin
          if (scan_idx == LAST_IDX) begin
            state_next = ST_DONE;
          end else begin
            scan_idx_next = scan_idx + SW'(1);
          end
        end
      end
      ST_DONE: begin
        if (cmd.finish) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      scan_idx <= '0;
    end else begin
      state    <= state_next;
      scan_idx <= scan_idx_next;
    end
  end

endmodule

// ===== hw/rtl/tmsb_datapath.sv =====
// Datapath with the slot registers, the pending expiry and the output register.
module tmsb_datapath #(
  parameter int NUM_SLOTS   = 8,
  parameter int COUNT_WIDTH = 32
) (
  input  logic                              clk,
  input  logic                              rst,
  input  tmsb_pkg::cmd_t                    cmd,
  input  logic [((NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1)-1:0] scan_idx,
  input  logic [tmsb_pkg::OP_W-1:0]         in_operation,
  input  logic [tmsb_pkg::TIMEOUT_W-1:0]    in_timeout_ticks,
  input  logic                              in_is_periodic,
  input  logic [tmsb_pkg::SLOT_ID_W-1:0]    in_slot_id,
  input  logic                              m_tready,
  output tmsb_pkg::status_t                 status,
  output logic                              out_valid,
  output logic [tmsb_pkg::KIND_W-1:0]       out_kind,
  output logic [tmsb_pkg::SLOT_ID_W-1:0]    out_slot,
  output logic                              out_tick_idle,
  output logic                              out_last
);

  localparam int SW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

  logic [NUM_SLOTS-1:0]   enabled;
  logic [NUM_SLOTS-1:0]   periodic;
  logic [COUNT_WIDTH-1:0] reload [NUM_SLOTS];
  logic [COUNT_WIDTH-1:0] count  [NUM_SLOTS];
  logic                   pend_valid;
  logic [SW-1:0]          pend_idx;

  logic                   free_found;
  logic [SW-1:0]          free_idx;
  logic [SW-1:0]          sid_idx;
  logic                   stop_ok;
  logic                   do_start;
  logic                   do_stop;
  logic                   hit;
  logic                   scan_en;
  logic                   push;
  logic [COUNT_WIDTH-1:0] timeout_cw;
  logic [tmsb_pkg::KIND_W-1:0]    push_kind;
  logic [tmsb_pkg::SLOT_ID_W-1:0] push_slot;
  logic                   push_idle;
  logic                   push_last;

  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
      if (!enabled[i]) begin
        free_found = 1'b1;
        free_idx   = SW'(i);
      end
    end
  end

  always_comb begin
    timeout_cw = COUNT_WIDTH'(in_timeout_ticks);
    sid_idx    = SW'(in_slot_id);
    stop_ok    = (int'(in_slot_id) < NUM_SLOTS) && enabled[sid_idx];
    do_start   = cmd.accept && (in_operation == tmsb_pkg::OP_START);
    do_stop    = cmd.accept && (in_operation == tmsb_pkg::OP_STOP);
    scan_en    = enabled[scan_idx];
    hit        = scan_en && (count[scan_idx] == '0);

    status.hit        = hit;
    status.pend_valid = pend_valid;
    status.can_load   = !out_valid || m_tready;

    push      = do_start || do_stop || (cmd.scan_step && hit && pend_valid) || cmd.finish;
    push_kind = tmsb_pkg::KIND_EXPIRED;
    push_slot = tmsb_pkg::SLOT_ID_W'(pend_idx);
    push_idle = 1'b0;
    push_last = 1'b1;
    if (do_start) begin
      push_kind = free_found ? tmsb_pkg::KIND_STARTED : tmsb_pkg::KIND_FULL;
      push_slot = free_found ? tmsb_pkg::SLOT_ID_W'(free_idx) : '0;
    end else if (do_stop) begin
      push_kind = stop_ok ? tmsb_pkg::KIND_STOPPED : tmsb_pkg::KIND_ALREADY;
      push_slot = in_slot_id;
    end else if (cmd.scan_step) begin
      push_last = 1'b0;
    end else if (!pend_valid) begin
      push_slot = '0;
      push_idle = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      enabled    <= '0;
      periodic   <= '0;
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (do_start && free_found) begin
        enabled[free_idx]  <= 1'b1;
        periodic[free_idx] <= in_is_periodic;
      end
      if (do_stop && stop_ok) begin
        enabled[sid_idx]  <= 1'b0;
        periodic[sid_idx] <= 1'b0;
      end
      if (cmd.scan_step && hit && !periodic[scan_idx]) begin
        enabled[scan_idx] <= 1'b0;
      end
      if (cmd.scan_start) begin
        pend_valid <= 1'b0;
      end else if (cmd.scan_step && hit) begin
        pend_valid <= 1'b1;
      end
      if (push) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_start && free_found) begin
      reload[free_idx] <= timeout_cw;
      count[free_idx]  <= timeout_cw;
    end
    if (cmd.scan_step && scan_en) begin
      if (hit) begin
        if (periodic[scan_idx]) begin
          count[scan_idx] <= reload[scan_idx];
        end
      end else begin
        count[scan_idx] <= count[scan_idx] - COUNT_WIDTH'(1);
      end
    end
    if (cmd.scan_step && hit) begin
      pend_idx <= scan_idx;
    end
    if (push) begin
      out_kind      <= push_kind;
      out_slot      <= push_slot;
      out_tick_idle <= push_idle;
      out_last      <= push_last;
    end
  end

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    push |-> (!out_valid || m_tready))
    else $error("result loaded over an unaccepted result");

  a_start_claims: assert property (@(posedge clk) disable iff (rst)
    (do_start && free_found) |=> ($countones(enabled) == $past($countones(enabled)) + 1))
    else $error("start did not claim exactly one slot");

  a_finish_last: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |=> (out_valid && out_last && (out_kind == tmsb_pkg::KIND_EXPIRED)))
    else $error("tick did not close with a last expiry result");

  a_idle_only_alone: assert property (@(posedge clk) disable iff (rst)
    (push && push_idle) |-> (cmd.finish && !pend_valid))
    else $error("idle result given for a tick with an expiry");

endmodule

// ===== hw/rtl/multi_slot_timer_bank_core.sv =====
// Top level of the timer bank: stream ports, controller and datapath.
//
// The block holds NUM_SLOTS timers of COUNT_WIDTH bits. A start or stop transaction
// gives one result; a tick transaction walks the slots one per cycle through a single
// count decrement unit, pausing while an expiry result waits in the output register
// and the tick must load the next one. A tick gives one expiry result per expired
// slot (the final one with tlast) or one idle result. Unused operation codes are
// consumed with no result. A new transaction is taken only while the output register
// is empty or its result is taken in the same cycle.
module multi_slot_timer_bank_core #(
  parameter int NUM_SLOTS   = 8,
  parameter int COUNT_WIDTH = 32
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  // timeout_ticks[31:0], is_periodic[32], slot_id[35:33], zero fill above
  input  logic [tmsb_pkg::S_TDATA_W-1:0]   s_tdata,
  // operation[1:0]
  input  logic [tmsb_pkg::OP_W-1:0]        s_tuser,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // slot[2:0], zero fill above
  output logic [tmsb_pkg::M_TDATA_W-1:0]   m_tdata,
  // kind[2:0], tick_idle[3]
  output logic [tmsb_pkg::M_TUSER_W-1:0]   m_tuser,
  output logic                             m_tlast
);

  localparam int SW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

  tmsb_pkg::cmd_t                 cmd;
  tmsb_pkg::status_t              status;
  logic [SW-1:0]                  scan_idx;
  logic [tmsb_pkg::KIND_W-1:0]    out_kind;
  logic [tmsb_pkg::SLOT_ID_W-1:0] out_slot;
  logic                           out_tick_idle;

  tmsb_ctrl #(
    .NUM_SLOTS (NUM_SLOTS)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .op       (s_tuser),
    .status   (status),
    .s_tready (s_tready),
    .cmd      (cmd),
    .scan_idx (scan_idx)
  );

  tmsb_datapath #(
    .NUM_SLOTS   (NUM_SLOTS),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_datapath (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .scan_idx         (scan_idx),
    .in_operation     (s_tuser),
    .in_timeout_ticks (s_tdata[31:0]),
    .in_is_periodic   (s_tdata[32]),
    .in_slot_id       (s_tdata[35:33]),
    .m_tready         (m_tready),
    .status           (status),
    .out_valid        (m_tvalid),
    .out_kind         (out_kind),
    .out_slot         (out_slot),
    .out_tick_idle    (out_tick_idle),
    .out_last         (m_tlast)
  );

  assign m_tdata = {{(tmsb_pkg::M_TDATA_W - tmsb_pkg::SLOT_ID_W){1'b0}}, out_slot};
  assign m_tuser = {out_tick_idle, out_kind};

endmodule

// ===== sim/tmsb_checker.sv =====
// Checker that tracks the timer slots, predicts each result and compares the output stream.
module tmsb_checker #(
  parameter int NUM_SLOTS = 8
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  input  logic                           s_tready,
  input  logic [tmsb_pkg::S_TDATA_W-1:0] s_tdata,
  input  logic [tmsb_pkg::OP_W-1:0]      s_tuser,
  input  logic                           m_tvalid,
  input  logic                           m_tready,
  input  logic [tmsb_pkg::M_TDATA_W-1:0] m_tdata,
  input  logic [tmsb_pkg::M_TUSER_W-1:0] m_tuser,
  input  logic                           m_tlast,
  output int                             mismatches,
  output int                             awaited
);
  import tmsb_pkg::*;

  typedef struct packed {
    logic [KIND_W-1:0]    kind;
    logic [SLOT_ID_W-1:0] slot;
    logic                 tick_idle;
    logic                 last;
  } timer_event_t;

  logic                 slot_on       [NUM_SLOTS];
  logic                 slot_repeats  [NUM_SLOTS];
  logic [TIMEOUT_W-1:0] slot_period   [NUM_SLOTS];
  logic [TIMEOUT_W-1:0] slot_remaining[NUM_SLOTS];
  timer_event_t         due_events[$];

  function automatic timer_event_t make_event(input logic [KIND_W-1:0] kind,
                                              input logic [SLOT_ID_W-1:0] slot,
                                              input logic idle, input logic last);
    timer_event_t ev;
    ev.kind      = kind;
    ev.slot      = slot;
    ev.tick_idle = idle;
    ev.last      = last;
    return ev;
  endfunction

  task automatic advance_bank(input logic [OP_W-1:0] op, input logic [TIMEOUT_W-1:0] timeout,
                              input logic repeats, input logic [SLOT_ID_W-1:0] sid);
    int           first_new;
    int           free_slot;
    timer_event_t tail;
    first_new = due_events.size();
    free_slot = -1;
    case (op)
      OP_TICK: begin
        for (int i = 0; i < NUM_SLOTS; i++) begin
          if (slot_on[i]) begin
            if (slot_remaining[i] == '0) begin
              if (slot_repeats[i]) begin
                slot_remaining[i] = slot_period[i];
              end else begin
                slot_on[i] = 1'b0;
              end
              due_events.push_back(make_event(KIND_EXPIRED, SLOT_ID_W'(i), 1'b0, 1'b0));
            end else begin
              slot_remaining[i] = slot_remaining[i] - TIMEOUT_W'(1);
            end
          end
        end
        if (due_events.size() == first_new) begin
          due_events.push_back(make_event(KIND_EXPIRED, '0, 1'b1, 1'b1));
        end else begin
          tail = due_events.pop_back();
          tail.last = 1'b1;
          due_events.push_back(tail);
        end
      end
      OP_START: begin
        for (int i = 0; i < NUM_SLOTS; i++) begin
          if (free_slot < 0 && !slot_on[i]) free_slot = i;
        end
        if (free_slot >= 0) begin
          slot_on[free_slot]        = 1'b1;
          slot_repeats[free_slot]   = repeats;
          slot_period[free_slot]    = timeout;
          slot_remaining[free_slot] = timeout;
          due_events.push_back(make_event(KIND_STARTED, SLOT_ID_W'(free_slot), 1'b0, 1'b1));
        end else begin
          due_events.push_back(make_event(KIND_FULL, '0, 1'b0, 1'b1));
        end
      end
      OP_STOP: begin
        if (int'(sid) < NUM_SLOTS && slot_on[sid]) begin
          slot_on[sid]        = 1'b0;
          slot_repeats[sid]   = 1'b0;
          slot_period[sid]    = '1;
          slot_remaining[sid] = '1;
          due_events.push_back(make_event(KIND_STOPPED, sid, 1'b0, 1'b1));
        end else begin
          due_events.push_back(make_event(KIND_ALREADY, sid, 1'b0, 1'b1));
        end
      end
      default: begin
      end
    endcase
  endtask

  task automatic flag_result(input string why, input timer_event_t want,
                             input timer_event_t seen);
    if (mismatches < 10) begin
      $display("%0t: %s: expected kind %0d slot %0d idle %0b last %0b,",
               $time, why, want.kind, want.slot, want.tick_idle, want.last,
               " got kind %0d slot %0d idle %0b last %0b",
               seen.kind, seen.slot, seen.tick_idle, seen.last);
    end
    mismatches++;
  endtask

  always @(posedge clk) begin : monitor
    timer_event_t seen;
    timer_event_t want;
    if (rst) begin
      for (int i = 0; i < NUM_SLOTS; i++) begin
        slot_on[i]        = 1'b0;
        slot_repeats[i]   = 1'b0;
        slot_period[i]    = '1;
        slot_remaining[i] = '1;
      end
      due_events.delete();
      mismatches = 0;
    end else begin
      if (m_tvalid && m_tready) begin
        seen = make_event(m_tuser[KIND_W-1:0], m_tdata[SLOT_ID_W-1:0], m_tuser[KIND_W], m_tlast);
        if (due_events.size() == 0) begin
          flag_result("result with none outstanding", '0, seen);
        end else begin
          want = due_events.pop_front();
          if (seen.kind !== want.kind || seen.slot !== want.slot ||
              seen.tick_idle !== want.tick_idle || seen.last !== want.last) begin
            flag_result("result mismatch", want, seen);
          end
        end
      end
      if (s_tvalid && s_tready) begin
        advance_bank(s_tuser, s_tdata[TIMEOUT_W-1:0], s_tdata[TIMEOUT_W],
                     s_tdata[TIMEOUT_W+SLOT_ID_W:TIMEOUT_W+1]);
      end
    end
    awaited <= due_events.size();
  end

endmodule

// ===== sim/tb_top.sv =====
// Top of the timer bank testbench: clock, reset, stream stimulus and the final verdict.
module tb_top;
  import tmsb_pkg::*;

  localparam int NUM_SLOTS = 8;
  localparam int FILL_W    = S_TDATA_W - TIMEOUT_W - SLOT_ID_W - 1;
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  logic                 clk      = 1'b0;
  logic                 rst      = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [S_TDATA_W-1:0] s_tdata  = '0;
  logic [OP_W-1:0]      s_tuser  = OP_TICK;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_tdata;
  logic [M_TUSER_W-1:0] m_tuser;
  logic                 m_tlast;
  int                   mismatches;
  int                   awaited;
  int                   stall_left    = 0;
  bit                   steady_source = 1'b0;
  bit                   steady_sink   = 1'b0;

  multi_slot_timer_bank_core #(
    .NUM_SLOTS  (NUM_SLOTS),
    .COUNT_WIDTH(TIMEOUT_W)
  ) DUT (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser),
    .m_tlast (m_tlast)
  );

  tmsb_checker #(
    .NUM_SLOTS(NUM_SLOTS)
  ) checker_i (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast),
    .mismatches(mismatches),
    .awaited   (awaited)
  );

  always #1 clk = ~clk;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 20);
  endfunction

  always @(negedge clk) begin
    if (stall_left > 0) begin
      m_tready   <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      m_tready <= 1'b1;
      if (!steady_sink && $urandom_range(0, 3) == 0) stall_left <= pick_gap();
    end
  end

  task automatic send_item(input logic [OP_W-1:0] op, input logic [TIMEOUT_W-1:0] timeout,
                           input logic repeats, input logic [SLOT_ID_W-1:0] sid);
    int gap;
    gap = steady_source ? 0 : pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {{FILL_W{1'b0}}, sid, repeats, timeout};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_random_item(output bit counted);
    int                   r;
    logic [TIMEOUT_W-1:0] timeout;
    r = $urandom_range(0, 99);
    counted = 1'b1;
    if (r < 70) timeout = $urandom_range(0, 6);
    else if (r < 85) timeout = $urandom_range(7, 40);
    else if (r < 95) timeout = $urandom;
    else timeout = '1;
    r = $urandom_range(0, 99);
    if (r < 45) begin
      send_item(OP_TICK, $urandom, 1'($urandom_range(0, 1)), 3'($urandom_range(0, 7)));
    end else if (r < 75) begin
      send_item(OP_START, timeout, 1'($urandom_range(0, 1)), 3'($urandom_range(0, 7)));
    end else if (r < 95) begin
      send_item(OP_STOP, $urandom, 1'($urandom_range(0, 1)), 3'($urandom_range(0, 7)));
    end else begin
      send_item(OP_UNUSED, $urandom, 1'($urandom_range(0, 1)), 3'($urandom_range(0, 7)));
      counted = 1'b0;
    end
  endtask

  initial begin
    int  sent;
    bit  counted;
    sent = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: empty bank, filling every slot, a full bank, multiple expiries per tick,
    // periodic reload, stops of running and idle slots, and an unused operation code.
    send_item(OP_TICK, '0, 1'b0, '0);
    send_item(OP_STOP, '0, 1'b0, 3'd3);
    send_item(OP_START, 32'd0, 1'b0, '0);
    send_item(OP_START, 32'd0, 1'b1, '0);
    send_item(OP_START, 32'd1, 1'b1, '0);
    send_item(OP_START, 32'hFFFF_FFFF, 1'b0, '0);
    send_item(OP_START, 32'd2, 1'b1, '0);
    send_item(OP_START, 32'hFFFF_FFFF, 1'b1, '1);
    send_item(OP_START, 32'd0, 1'b0, '0);
    send_item(OP_START, 32'd3, 1'b0, '0);
    send_item(OP_START, 32'd5, 1'b1, '0);
    send_item(OP_TICK, '1, 1'b1, '1);
    send_item(OP_TICK, '0, 1'b0, '0);
    send_item(OP_STOP, '1, 1'b1, 3'd3);
    send_item(OP_STOP, '0, 1'b0, 3'd0);
    send_item(OP_UNUSED, 32'h1234_5678, 1'b1, 3'd5);
    send_item(OP_START, 32'hA5A5_A5A5, 1'b1, '0);
    send_item(OP_TICK, '0, 1'b0, '0);
    send_item(OP_STOP, '0, 1'b0, 3'd5);
    send_item(OP_STOP, '0, 1'b0, 3'd7);
    send_item(OP_TICK, '0, 1'b0, '0);
    send_item(OP_TICK, '0, 1'b0, '0);
    send_item(OP_STOP, '0, 1'b0, 3'd2);

    while (sent < 150) begin
      if (sent % 25 == 0) begin
        steady_source = ($urandom_range(0, 3) == 0);
        steady_sink   = ($urandom_range(0, 3) == 0);
      end
      send_random_item(counted);
      if (counted) sent++;
    end

    s_tvalid <= 1'b0;
    steady_sink = 1'b0;
    while (awaited != 0) @(negedge clk);
    repeat (NUM_SLOTS + 8) @(negedge clk);
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("Test completed with failures");
    $finish;
  end

endmodule

// ===== multi_slot_timer_bank_core.f =====
hw/rtl/tmsb_pkg.sv
hw/rtl/tmsb_ctrl.sv
hw/rtl/tmsb_datapath.sv
hw/rtl/multi_slot_timer_bank_core.sv
sim/tmsb_checker.sv
sim/tb_top.sv
